@@ rtl/core/dcpr_pkg.sv @@
`timescale 1ns / 1ps
package dcpr_pkg;

   localparam int PktLen       = 5;
   localparam int BodyBytes    = PktLen - 1;
   localparam int CountWidth   = $clog2(PktLen);
   localparam int TimerWidth   = 16;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 16;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrW    = $clog2(QueueDepth);
   localparam int QueueCntW    = $clog2(QueueDepth + 1);

   localparam logic [3:0]            MaxHop       = 4'hf;
   localparam logic [TimerWidth-1:0] TimeoutReset = 16'd100;

   // input commands
   localparam logic [1:0] CMD_PLUG_BYTE   = 2'd0;
   localparam logic [1:0] CMD_SOCKET_BYTE = 2'd1;
   localparam logic [1:0] CMD_TICK        = 2'd2;

   // result destinations
   localparam logic [1:0] DEST_TO_PLUG      = 2'd0;
   localparam logic [1:0] DEST_TO_SOCKET    = 2'd1;
   localparam logic [1:0] DEST_LOCAL_PLUG   = 2'd2;
   localparam logic [1:0] DEST_LOCAL_SOCKET = 2'd3;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_PLUG_PRESENT   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SOCKET_PRESENT = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_TIMEOUT_TICKS  = 2'd2;

   typedef struct packed {
      logic byte_en;
      logic tick_en;
   } gather_ctl_type;

   typedef struct packed {
      logic [1:0]  destination;
      logic [7:0]  header_byte;
      logic [31:0] payload_word;
      logic        last_result;
   } rsp_item_type;

endpackage

@@ rtl/core/dcpr_gather.sv @@
`timescale 1ns / 1ps
module dcpr_gather (
   input  logic                            clock,
   input  logic                            reset,
   input  dcpr_pkg::gather_ctl_type        ctl,
   input  logic [7:0]                      byte_value,
   input  logic [dcpr_pkg::TimerWidth-1:0] timeout_ticks,
   output logic                            done,
   output logic [7:0]                      header_byte,
   output logic [31:0]                     payload_word
);
   import dcpr_pkg::*;

   logic [7:0]            bytes_ff [BodyBytes];
   logic [CountWidth-1:0] count_ff, count_in;
   logic [TimerWidth-1:0] timer_ff, timer_in;
   logic                  full;

   assign full         = (count_ff == CountWidth'(BodyBytes));
   assign done         = ctl.byte_en && full;
   assign header_byte  = bytes_ff[0];
   assign payload_word = {bytes_ff[1], bytes_ff[2], bytes_ff[3], byte_value};

   always_comb begin
      count_in = count_ff;
      timer_in = timer_ff;
      if (ctl.byte_en) begin
         if (full) begin
            count_in = '0;
            timer_in = '0;
         end else begin
            count_in = count_ff + 1'b1;
            if (count_ff == '0) begin
               timer_in = '0;
            end
         end
      end else if (ctl.tick_en && count_ff != '0) begin
         // partial packet ages out once its timer has reached the limit
         if (timer_ff >= timeout_ticks) begin
            count_in = '0;
            timer_in = '0;
         end else begin
            timer_in = timer_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         timer_ff <= '0;
      end else begin
         count_ff <= count_in;
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.byte_en && !full) begin
         bytes_ff[count_ff[$clog2(BodyBytes)-1:0]] <= byte_value;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(BodyBytes))
      else $error("gather count out of range");

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      ctl.byte_en && count_ff == '0 |=> count_ff == 1 && timer_ff == '0)
      else $error("first byte did not start a fresh packet");

   a_timeout_drop: assert property (@(posedge clock) disable iff (reset)
      ctl.tick_en && !ctl.byte_en && count_ff != '0 && timer_ff >= timeout_ticks
      |=> count_ff == '0)
      else $error("expired partial packet was not dropped");
`endif

endmodule

@@ rtl/core/dcpr_rsp_queue.sv @@
`timescale 1ns / 1ps
module dcpr_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_n,
   input  dcpr_pkg::rsp_item_type item0,
   input  dcpr_pkg::rsp_item_type item1,
   input  logic                   pop,
   output logic                   room_for_two,
   output logic                   not_empty,
   output dcpr_pkg::rsp_item_type head
);
   import dcpr_pkg::*;

   rsp_item_type         mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic                 do_pop;

   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= QueueCntW'(QueueDepth - 2));
   assign head         = mem_ff[rd_ptr_ff];
   assign do_pop       = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(push_n);
      rd_ptr_in = rd_ptr_ff + QueuePtrW'(do_pop);
      count_in  = count_ff + QueueCntW'(push_n) - QueueCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= item0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + 1'b1] <= item1;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("response queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> room_for_two)
      else $error("push into response queue without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      push_n == 2'd0 && do_pop |=> count_ff == $past(count_ff) - 1'b1)
      else $error("response queue count did not drop on pop");
`endif

endmodule

@@ rtl/core/daisy_chain_packet_router.sv @@
`timescale 1ns / 1ps
// Daisy-chain router node. The req channel carries one command per
// transaction: a byte from the plug port, a byte from the socket port, or a
// one microsecond tick. Each port gathers 5-byte packets; a finished packet
// comes out on the rsp channel as up to two transactions (forward and/or
// local delivery), the last one flagged by rsp_last_result.
// The csr port writes plug_present (0), socket_present (1) and
// timeout_ticks (2) with no wait state; write only while the block is idle.
// Timing: a command is captured in an input register and processed while the
// response queue has room for two results; its results then enter the queue,
// whose registered count drives rsp_valid.
// One command is taken per cycle; the input register advances only while
// the 4-entry response queue has room for two results, so a stalled rsp
// receiver backs up into req_ready once three results are waiting.
// Reset clears both gatherers and the queue and loads the configuration
// defaults: both ports present, timeout of 100 ticks.
module daisy_chain_packet_router (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic [7:0]                        req_byte_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_destination,
   output logic [7:0]                        rsp_header_byte,
   output logic [31:0]                       rsp_payload_word,
   output logic                              rsp_last_result,
   input  logic                              csr_write_enable,
   input  logic [dcpr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [dcpr_pkg::CsrDataWidth-1:0] csr_write_data
);
   import dcpr_pkg::*;

   logic                  plug_present_ff;
   logic                  socket_present_ff;
   logic [TimerWidth-1:0] timeout_ticks_ff;

   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_byte_ff;

   logic           step;
   logic           room_for_two;
   gather_ctl_type plug_ctl, socket_ctl;
   logic           plug_done, socket_done;
   logic [7:0]     plug_hdr, socket_hdr;
   logic [31:0]    plug_pay, socket_pay;
   logic [3:0]     plug_addr, socket_addr;
   logic           socket_fwd;

   logic [1:0]   push_n;
   rsp_item_type item0, item1, head;
   logic         not_empty;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         plug_present_ff   <= 1'b1;
         socket_present_ff <= 1'b1;
         timeout_ticks_ff  <= TimeoutReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PLUG_PRESENT:   plug_present_ff   <= csr_write_data[0];
            CSR_SOCKET_PRESENT: socket_present_ff <= csr_write_data[0];
            CSR_TIMEOUT_TICKS:  timeout_ticks_ff  <= csr_write_data[TimerWidth-1:0];
            default: ;
         endcase
      end
   end

   // input register
   assign step      = in_valid_ff && room_for_two;
   assign req_ready = !in_valid_ff || room_for_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_byte_value;
      end
   end

   always_comb begin
      plug_ctl   = '0;
      socket_ctl = '0;
      if (step) begin
         case (in_cmd_ff)
            CMD_PLUG_BYTE:   plug_ctl.byte_en   = plug_present_ff;
            CMD_SOCKET_BYTE: socket_ctl.byte_en = socket_present_ff;
            CMD_TICK: begin
               plug_ctl.tick_en   = 1'b1;
               socket_ctl.tick_en = 1'b1;
            end
            default: ;
         endcase
      end
   end

   dcpr_gather u_plug_gather (
      .clock         (clock),
      .reset         (reset),
      .ctl           (plug_ctl),
      .byte_value    (in_byte_ff),
      .timeout_ticks (timeout_ticks_ff),
      .done          (plug_done),
      .header_byte   (plug_hdr),
      .payload_word  (plug_pay)
   );

   dcpr_gather u_socket_gather (
      .clock         (clock),
      .reset         (reset),
      .ctl           (socket_ctl),
      .byte_value    (in_byte_ff),
      .timeout_ticks (timeout_ticks_ff),
      .done          (socket_done),
      .header_byte   (socket_hdr),
      .payload_word  (socket_pay)
   );

   assign plug_addr   = plug_hdr[7:4];
   assign socket_addr = socket_hdr[7:4];
   assign socket_fwd  = plug_present_ff && (socket_addr != MaxHop);

   // routing of a finished packet
   always_comb begin
      push_n = 2'd0;
      item0  = '{destination: DEST_LOCAL_PLUG, header_byte: plug_hdr,
                 payload_word: plug_pay, last_result: 1'b1};
      item1  = '{destination: DEST_LOCAL_SOCKET, header_byte: socket_hdr,
                 payload_word: socket_pay, last_result: 1'b1};
      if (plug_done) begin
         if (plug_addr == 4'd0) begin
            push_n = 2'd1;
         end else if (socket_present_ff) begin
            push_n             = 2'd1;
            item0.destination  = DEST_TO_SOCKET;
            item0.header_byte  = {plug_addr - 4'd1, plug_hdr[3:0]};
         end
      end else if (socket_done) begin
         if (socket_fwd) begin
            push_n = 2'd2;
            item0  = '{destination: DEST_TO_PLUG,
                       header_byte: {socket_addr + 4'd1, socket_hdr[3:0]},
                       payload_word: socket_pay, last_result: 1'b0};
         end else begin
            push_n = 2'd1;
            item0  = item1;
         end
      end
   end

   dcpr_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push_n       (push_n),
      .item0        (item0),
      .item1        (item1),
      .pop          (rsp_ready),
      .room_for_two (room_for_two),
      .not_empty    (not_empty),
      .head         (head)
   );

   assign rsp_valid        = not_empty;
   assign rsp_destination  = head.destination;
   assign rsp_header_byte  = head.header_byte;
   assign rsp_payload_word = head.payload_word;
   assign rsp_last_result  = head.last_result;

`ifndef ASSERT_OFF
   a_one_port_done: assert property (@(posedge clock) disable iff (reset)
      !(plug_done && socket_done))
      else $error("both ports finished a packet in one cycle");

   a_done_needs_step: assert property (@(posedge clock) disable iff (reset)
      (plug_done || socket_done) |-> step)
      else $error("packet finished without a processed transaction");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room_for_two |=> in_valid_ff && $stable(in_cmd_ff)
      && $stable(in_byte_ff))
      else $error("stalled input register changed");
`endif

endmodule
